FILE: design/tmsb_pkg.sv
// shared types and constants for the text mode screen buffer
package tmsb_pkg;
    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = 16;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'hf0;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_LF        = 8'd10;

    localparam logic CFG_CLEAR_ATTR  = 1'b0;
    localparam logic CFG_SCROLL_ATTR = 1'b1;

    localparam logic [2:0] F_CHAR   = 3'd0;
    localparam logic [2:0] F_SCROLL = 3'd1;
    localparam logic [2:0] F_FILL   = 3'd2;
    localparam logic [2:0] F_CLEAR  = 3'd3;
    localparam logic [2:0] F_READ   = 3'd4;
    localparam logic [2:0] F_WRITE  = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RUN    = 7'b0000010,
        S_SCRD   = 7'b0000100,
        S_SCWR   = 7'b0001000,
        S_FILL   = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;
endpackage

FILE: design/tmsb_ram.sv
// generic single port write, single port read ram with registered read
module tmsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/text_mode_screen_buffer_unit.sv
// top level of the text mode screen buffer
// usage:
//   input channel i_valid/o_ready carries one command per transfer; output
//   channel o_valid/i_ready returns exactly one result per command.
//   config channel i_cfg_valid/o_cfg_ready writes clear_attr (index 0) or
//   scroll_fill_attr (index 1); write only while idle.
// storage:
//   one ram of ROWS*COLS 16-bit cells {char, attr}, registered read.
// operation:
//   string char and write cell write the ram when taken; read cell
//   reads one cell. fill reads then writes back each (clipped) cell;
//   clear writes every cell. scroll reads then writes each moved cell,
//   then blanks the bottom row. commands are handled one at a time,
//   since the single ram port pair is walked by one sequencer.
// reset:
//   a clearing pass writes blanks with the reset clear attribute to every
//   cell and gives no result; no command is taken until it ends.
// stall:
//   the result sits in an output register until taken; the next command
//   is accepted in the same cycle the result transfers.
module text_mode_screen_buffer_unit
    import tmsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_row,
    input  logic [6:0]  i_col,
    input  logic [4:0]  i_bottom_row,
    input  logic [7:0]  i_attr,
    input  logic [7:0]  i_ch,
    input  logic [10:0] i_count,
    input  logic        i_first_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    output logic [4:0]  o_end_row,
    output logic [6:0]  o_end_col,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    t_state r_state, n_state;
    logic [7:0] r_clear_attr, r_scroll_attr;
    // cursor state
    logic [4:0] r_cur_row, n_cur_row;
    logic signed [8:0] r_cur_col, n_cur_col;
    logic [7:0] r_start_col, n_start_col;
    // sweep pointers: write address, end, data
    logic [AW-1:0] r_ptr, n_ptr, r_end, n_end;
    logic [DW-1:0] r_wdata, n_wdata;
    logic [AW-1:0] r_band_end, n_band_end; // last address moved in scroll
    logic [7:0] r_fill_attr, n_fill_attr;
    logic r_attr_only, n_attr_only;
    logic [7:0] r_oc, n_oc, r_oa, n_oa;
    logic [4:0] r_or, n_or;
    logic [6:0] r_ocol, n_ocol;
    logic r_valid, n_valid;
    // set during the clearing pass after reset, which has no result
    logic r_init, n_init;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    tmsb_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready     = (r_state == S_IDLE) && (!r_valid || i_ready);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_read_char = r_oc;
    assign o_read_attr = r_oa;
    assign o_end_row   = r_or;
    assign o_end_col   = r_ocol;

    // linear cell address of row/col (col may exceed a row)
    function automatic logic [12:0] lin(input logic [4:0] r, input logic [7:0] c);
        lin = 13'(r * COLS) + 13'(c);
    endfunction

    logic [12:0] a_lin, a_end;
    logic [4:0] bot_sat, c_row;
    logic [7:0] c_col, st;
    logic signed [8:0] cc;
    logic is_brk;

    always_comb begin
        n_state = r_state; n_cur_row = r_cur_row; n_cur_col = r_cur_col;
        n_start_col = r_start_col; n_ptr = r_ptr; n_end = r_end;
        n_wdata = r_wdata; n_band_end = r_band_end; n_fill_attr = r_fill_attr;
        n_attr_only = r_attr_only; n_oc = r_oc; n_oa = r_oa; n_or = r_or;
        n_ocol = r_ocol; n_valid = r_valid; n_init = r_init;
        we = 1'b0; waddr = r_ptr; wdata = r_wdata; raddr = r_ptr;
        a_lin = lin(i_row, {1'b0, i_col});
        a_end = a_lin + 13'(i_count);
        bot_sat = (i_bottom_row >= 5'(ROWS)) ? 5'(ROWS - 1) : i_bottom_row;
        c_row = r_cur_row; cc = r_cur_col; st = r_start_col; c_col = 8'd0;
        is_brk = (i_ch == CH_CR) || (i_ch == CH_LF);
        if (r_valid && i_ready) n_valid = 1'b0;
        unique case (r_state)
            S_RUN: begin
                // clear sweep (also the scroll blank row and reset pass), one cell a cycle
                we = 1'b1;
                wdata = r_attr_only ? {rdata[15:8], r_fill_attr} : r_wdata;
                if (r_attr_only) begin
                    // no write here: fill runs in S_FILL and S_RDWAIT instead
                    we = 1'b0;
                end
                if (!r_attr_only) begin
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == r_end) begin
                        n_state = r_init ? S_IDLE : S_OUT;
                        n_init = 1'b0;
                    end
                end
            end
            S_FILL: begin
                // read the cell at r_ptr; S_RDWAIT writes it back with the fill attr
                raddr = r_ptr;
                n_state = S_RDWAIT;
                n_attr_only = 1'b1;
            end
            S_RDWAIT: begin
                if (r_attr_only) begin
                    we = 1'b1; waddr = r_ptr;
                    wdata = {rdata[15:8], r_fill_attr};
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == r_end) n_state = S_OUT;
                    else n_state = S_FILL;
                end else begin
                    n_oc = rdata[15:8]; n_oa = rdata[7:0];
                    n_state = S_OUT;
                end
            end
            S_SCRD: begin
                // read the cell one row below
                raddr = r_ptr + AW'(COLS);
                n_state = S_SCWR;
            end
            S_SCWR: begin
                we = 1'b1; wdata = rdata;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == r_band_end) begin
                    n_state = S_RUN; n_attr_only = 1'b0;
                end else n_state = S_SCRD;
            end
            S_OUT: begin
                n_valid = 1'b1; n_state = S_IDLE;
            end
            default: begin
                if (i_valid && o_ready) begin
                    n_oc = 8'd0; n_oa = 8'd0; n_or = 5'd0; n_ocol = 7'd0;
                    n_state = S_OUT;
                    unique case (i_func)
                        F_CHAR: begin
                            if (i_first_char) begin
                                c_row = (i_row >= 5'(ROWS)) ? 5'(ROWS - 1) : i_row;
                                c_col = (i_col >= 7'(COLS)) ? 8'(COLS - 1) : {1'b0, i_col};
                                st = c_col;
                                cc = $signed({1'b0, c_col}) - 9'sd1;
                            end
                            if (is_brk) begin
                                if (c_row < 5'(ROWS - 1)) c_row = c_row + 1'b1;
                                cc = $signed({1'b0, st}) - 9'sd1;
                            end else begin
                                cc = cc + 9'sd1;
                                if (cc >= $signed(9'(COLS))) begin
                                    if (c_row < 5'(ROWS - 1)) c_row = c_row + 1'b1;
                                    cc = $signed({1'b0, st});
                                end
                                if (cc >= 9'sd0 && cc < $signed(9'(COLS))) begin
                                    we = 1'b1;
                                    waddr = AW'(lin(c_row, cc[7:0]));
                                    wdata = {i_ch, i_attr};
                                end
                            end
                            n_cur_row = c_row; n_cur_col = cc; n_start_col = st;
                            n_or = c_row;
                            n_ocol = 7'(cc + 9'sd1);
                        end
                        F_SCROLL: begin
                            n_end = AW'(lin(bot_sat, 8'(COLS - 1)));
                            n_wdata = {BLANK_CHAR, r_scroll_attr};
                            n_attr_only = 1'b0;
                            if (i_row < bot_sat) begin
                                n_ptr = AW'(lin(i_row, 8'd0));
                                n_band_end = AW'(lin(bot_sat, 8'd0) - 13'd1);
                                n_state = S_SCRD;
                            end else begin
                                n_ptr = AW'(lin(bot_sat, 8'd0));
                                n_state = S_RUN;
                            end
                        end
                        F_FILL: begin
                            if (i_count != 11'd0 && a_lin < 13'(CELLS)) begin
                                n_ptr = AW'(a_lin);
                                n_end = (a_end > 13'(CELLS)) ? AW'(CELLS - 1)
                                                             : AW'(a_end - 13'd1);
                                n_fill_attr = i_attr;
                                n_state = S_FILL;
                            end
                        end
                        F_CLEAR: begin
                            n_ptr = '0; n_end = AW'(CELLS - 1);
                            n_wdata = {BLANK_CHAR, r_clear_attr};
                            n_attr_only = 1'b0; n_state = S_RUN;
                        end
                        F_READ: begin
                            if (i_row < 5'(ROWS) && i_col < 7'(COLS)) begin
                                raddr = AW'(a_lin);
                                n_attr_only = 1'b0;
                                n_state = S_RDWAIT;
                            end
                        end
                        F_WRITE: begin
                            if (i_row < 5'(ROWS) && i_col < 7'(COLS)) begin
                                we = 1'b1; waddr = AW'(a_lin);
                                wdata = {i_ch, i_attr};
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // clearing pass after reset
            r_state <= S_RUN;
            r_ptr <= '0; r_end <= AW'(CELLS - 1);
            r_wdata <= {BLANK_CHAR, ATTR_RESET};
            r_attr_only <= 1'b0;
            r_valid <= 1'b0;
            r_init <= 1'b1;
            r_cur_row <= '0; r_cur_col <= '0; r_start_col <= '0;
            r_clear_attr <= ATTR_RESET; r_scroll_attr <= 8'h00;
        end else begin
            r_state <= n_state; r_ptr <= n_ptr; r_end <= n_end;
            r_wdata <= n_wdata; r_attr_only <= n_attr_only; r_valid <= n_valid;
            r_init <= n_init;
            r_cur_row <= n_cur_row; r_cur_col <= n_cur_col; r_start_col <= n_start_col;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLEAR_ATTR:  r_clear_attr  <= i_cfg_data;
                    CFG_SCROLL_ATTR: r_scroll_attr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_band_end <= n_band_end; r_fill_attr <= n_fill_attr;
        r_oc <= n_oc; r_oa <= n_oa; r_or <= n_or; r_ocol <= n_ocol;
    end
endmodule
